// ===== sv/stack_machine_executor_assert.svh =====
// ----------------------------------------------------------------------------
// Stack machine executor assertion macros
// Concurrent check shorthands; the including module supplies clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SME_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SME_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor package
// Opcodes, status codes, FSM states and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package sme_pkg;

	localparam int CMD_W       = 3;
	localparam int CONST_W     = 32;
	localparam int VAR_INDEX_W = 4;
	localparam int STATUS_W    = 3;
	localparam int DEPTH_OUT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 3'd0,
		CMD_LOAD  = 3'd1,
		CMD_STORE = 3'd2,
		CMD_ADD   = 3'd3,
		CMD_SUB   = 3'd4,
		CMD_MUL   = 3'd5,
		CMD_DIV   = 3'd6,
		CMD_PRINT = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 3'd0,
		STAT_UNDEF = 3'd1,
		STAT_UNDER = 3'd2,
		STAT_DIVZ  = 3'd3,
		STAT_OVER  = 3'd4,
		STAT_HALT  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOAD,
		S_ARITH
	} state_t;

	// shift control shared by every stack cell
	typedef struct packed {
		logic push;
		logic pop;
	} cell_ctl_t;

	typedef struct packed {
		logic                   print_valid;
		logic [CONST_W-1:0]     print_value;
		status_t                status;
		logic [DEPTH_OUT_W-1:0] stack_depth;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/sme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/sme_cell.sv =====
// ----------------------------------------------------------------------------
// Stack cell
// One operand stack entry; shifts toward the bottom on push, toward the top on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_cell #(
	parameter int WIDTH = 32
) (
	input  wire logic              clk,
	input  wire sme_pkg::cell_ctl_t ctl,
	input  wire logic [WIDTH-1:0]  up_data,   // neighbor nearer the top, or new top
	input  wire logic [WIDTH-1:0]  dn_data,   // neighbor nearer the bottom
	output logic      [WIDTH-1:0]  q
);

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			q <= up_data;
		end else if (ctl.pop) begin
			q <= dn_data;
		end
	end

endmodule

`default_nettype wire

// ===== sv/sme_muldiv.sv =====
// ----------------------------------------------------------------------------
// Iterative multiply / divide
// Shift-add multiply or restoring signed divide, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sme_muldiv #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             is_div,
	input  wire logic [WIDTH-1:0] a,        // dividend / multiplicand
	input  wire logic [WIDTH-1:0] b,        // divisor / multiplier
	output logic                  done,
	output logic      [WIDTH-1:0] result
);

	localparam int CNW = $clog2(WIDTH);

	logic             busy_q;
	logic             done_q;
	logic [CNW-1:0]   cnt_q;
	logic             div_q;
	logic             neg_q;
	logic [WIDTH-1:0] acc_q;   // product, or partial remainder
	logic [WIDTH-1:0] x_q;     // multiplicand, or dividend / quotient
	logic [WIDTH-1:0] y_q;     // multiplier, or divisor magnitude

	logic [WIDTH-1:0] mag_a;
	logic [WIDTH-1:0] mag_b;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   diff;
	logic [WIDTH-1:0] acc_add;

	always_comb begin
		mag_a   = a[WIDTH-1] ? ('0 - a) : a;
		mag_b   = b[WIDTH-1] ? ('0 - b) : b;
		rem_sh  = {acc_q, x_q[WIDTH-1]};
		diff    = rem_sh - {1'b0, y_q};
		acc_add = acc_q + (y_q[0] ? x_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= is_div;
			neg_q <= a[WIDTH-1] ^ b[WIDTH-1];
			acc_q <= '0;
			x_q   <= is_div ? mag_a : a;
			y_q   <= is_div ? mag_b : b;
		end else if (busy_q) begin
			if (div_q) begin
				acc_q <= diff[WIDTH] ? rem_sh[WIDTH-1:0] : diff[WIDTH-1:0];
				x_q   <= {x_q[WIDTH-2:0], ~diff[WIDTH]};
			end else begin
				acc_q <= acc_add;
				x_q   <= {x_q[WIDTH-2:0], 1'b0};
				y_q   <= {1'b0, y_q[WIDTH-1:1]};
			end
		end
	end

	assign done   = done_q;
	assign result = div_q ? (neg_q ? ('0 - x_q) : x_q) : acc_q;

endmodule

`default_nettype wire

// ===== sv/stack_machine_executor.sv =====
// ----------------------------------------------------------------------------
// Stack machine executor
// Runs one stack-machine instruction per request and returns one result each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one instruction per request:
//   cmd, const_value, var_index. Output channel (out_valid/out_ready) carries
//   exactly one result per instruction: print_valid, print_value, status and
//   the stack depth after the instruction.
//   Completion: push, store, print, add, sub and any failing or halted
//   instruction finish in the cycle of acceptance; load passes through
//   S_LOAD for the variable RAM read; mul and div wait in S_ARITH for
//   the bit-serial unit. One instruction is in flight at a time, so a new
//   request is taken only once the FSM is back in S_IDLE.
//   A result register plus one skid entry sit on the output, so a new request
//   is taken while one result waits on a stalled receiver; with the skid entry
//   also full, in_ready drops until the receiver drains.
//   The stack is a chain of cells: the top entry sits in cell 0, and every
//   cell shifts to its neighbor on push and pop.
//   Reset empties the stack, clears all variable defined bits and the halt.
//   No clearing pass is needed. Any error halts; later requests report halted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stack_machine_executor_assert.svh"

module stack_machine_executor #(
	parameter int STACK_DEPTH = 16,
	parameter int NUM_VARS    = 16,
	parameter int DATA_WIDTH  = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// instruction requests
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic        [sme_pkg::CMD_W-1:0]       cmd,
	input  wire logic signed [sme_pkg::CONST_W-1:0]     const_value,
	input  wire logic        [sme_pkg::VAR_INDEX_W-1:0] var_index,
	// results
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      print_valid,
	output logic signed      [sme_pkg::CONST_W-1:0]     print_value,
	output logic             [sme_pkg::STATUS_W-1:0]    status,
	output logic             [sme_pkg::DEPTH_OUT_W-1:0] stack_depth
);

	import sme_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int VW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
	localparam int NUM_IDX = 2 ** VAR_INDEX_W;

	state_t state_q, nxt_state;

	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_d;
	logic                  halted_q;
	logic [NUM_VARS-1:0]   def_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  lt2;
	logic [VW-1:0]         vi;

	// stack cell chain
	logic [DATA_WIDTH-1:0] cell_q [STACK_DEPTH];
	cell_ctl_t             ctl;
	logic [DATA_WIDTH-1:0] new_top;
	logic [DATA_WIDTH-1:0] top_dn;

	// constant sign-extended (or cut) to the data width
	logic [DATA_WIDTH+CONST_W-1:0] cv_wide;
	logic [DATA_WIDTH-1:0]         cv_dw;

	// variable RAM
	logic                  ram_we;
	logic                  ram_re;
	logic [DATA_WIDTH-1:0] ram_rdata;

	// bit-serial multiply / divide
	logic                  md_start;
	logic                  md_div;
	logic                  md_done;
	logic [DATA_WIDTH-1:0] md_result;

	// result of the instruction finishing this cycle
	logic                  res_fire;
	status_t               res_status;
	logic                  res_print;
	logic [DATA_WIDTH-1:0] res_pval;
	logic                  cnt_inc;
	logic                  cnt_dec;
	logic [DATA_WIDTH+CONST_W-1:0] pv_wide;
	logic [CW+DEPTH_OUT_W-1:0]     depth_wide;
	result_t               res_d;

	// output register and skid entry
	logic                  out_valid_q;
	logic                  skid_valid_q;
	result_t               out_q;
	result_t               skid_q;
	logic                  out_taken;
	logic                  out_ld_res;
	logic                  out_ld_skid;
	logic                  skid_ld;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !skid_valid_q;

	assign full  = (cnt_q == CW'(STACK_DEPTH));
	assign empty = (cnt_q == '0);
	assign lt2   = (cnt_q < CW'(2));

	assign cv_wide = {{DATA_WIDTH{const_value[CONST_W-1]}}, const_value};
	assign cv_dw   = cv_wide[DATA_WIDTH-1:0];

	// variable index wraps modulo NUM_VARS: small constant lookup
	always_comb begin
		vi = '0;
		for (int k = 0; k < NUM_IDX; k++) begin
			if (var_index == VAR_INDEX_W'(k)) begin
				vi = VW'(k % NUM_VARS);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stack: cell 0 is the top; push shifts toward the bottom, pop toward
	// the top. A binary op pops once and overwrites the top with top_dn.
	// ------------------------------------------------------------------
	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] up_d;
		logic [DATA_WIDTH-1:0] dn_d;

		if (i == 0) begin : g_top
			assign up_d = new_top;
			assign dn_d = top_dn;
		end else if (i == STACK_DEPTH - 1) begin : g_bottom
			assign up_d = cell_q[i-1];
			assign dn_d = '0;
		end else begin : g_mid
			assign up_d = cell_q[i-1];
			assign dn_d = cell_q[i+1];
		end

		sme_cell #(
			.WIDTH (DATA_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.up_data (up_d),
			.dn_data (dn_d),
			.q       (cell_q[i])
		);
	end

	sme_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (NUM_VARS)
	) u_vars (
		.clk   (clk),
		.we    (ram_we),
		.waddr (vi),
		.wdata (cell_q[0]),
		.re    (ram_re),
		.raddr (vi),
		.rdata (ram_rdata)
	);

	sme_muldiv #(
		.WIDTH (DATA_WIDTH)
	) u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.is_div (md_div),
		.a      (cell_q[1]),
		.b      (cell_q[0]),
		.done   (md_done),
		.result (md_result)
	);

	// ------------------------------------------------------------------
	// Control FSM
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= nxt_state;
		end
	end

	always_comb begin
		nxt_state  = state_q;
		ctl        = '0;
		new_top    = cv_dw;
		top_dn     = cell_q[1];
		res_fire   = 1'b0;
		res_status = STAT_OK;
		res_print  = 1'b0;
		res_pval   = '0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		md_start   = 1'b0;
		md_div     = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_fire = 1'b1;
					if (halted_q) begin
						res_status = STAT_HALT;
					end else begin
						unique case (cmd_t'(cmd))
							CMD_PUSH: begin
								if (full) begin
									res_status = STAT_OVER;
								end else begin
									ctl.push = 1'b1;
									cnt_inc  = 1'b1;
								end
							end
							CMD_LOAD: begin
								// undefined wins over overflow
								if (!def_q[vi]) begin
									res_status = STAT_UNDEF;
								end else if (full) begin
									res_status = STAT_OVER;
								end else begin
									ram_re    = 1'b1;
									res_fire  = 1'b0;
									nxt_state = S_LOAD;
								end
							end
							CMD_STORE: begin
								if (empty) begin
									res_status = STAT_UNDER;
								end else begin
									ram_we  = 1'b1;
									ctl.pop = 1'b1;
									cnt_dec = 1'b1;
								end
							end
							CMD_PRINT: begin
								if (empty) begin
									res_status = STAT_UNDER;
								end else begin
									res_print = 1'b1;
									res_pval  = cell_q[0];
									ctl.pop   = 1'b1;
									cnt_dec   = 1'b1;
								end
							end
							CMD_ADD, CMD_SUB: begin
								if (lt2) begin
									res_status = STAT_UNDER;
								end else begin
									top_dn = (cmd_t'(cmd) == CMD_ADD) ?
										cell_q[1] + cell_q[0] :
										cell_q[1] - cell_q[0];
									ctl.pop = 1'b1;
									cnt_dec = 1'b1;
								end
							end
							CMD_MUL: begin
								if (lt2) begin
									res_status = STAT_UNDER;
								end else begin
									md_start  = 1'b1;
									res_fire  = 1'b0;
									nxt_state = S_ARITH;
								end
							end
							CMD_DIV: begin
								// underflow is checked before divide by zero
								if (lt2) begin
									res_status = STAT_UNDER;
								end else if (cell_q[0] == '0) begin
									res_status = STAT_DIVZ;
								end else begin
									md_start  = 1'b1;
									md_div    = 1'b1;
									res_fire  = 1'b0;
									nxt_state = S_ARITH;
								end
							end
						endcase
					end
				end
			end
			S_LOAD: begin
				new_top   = ram_rdata;
				ctl.push  = 1'b1;
				cnt_inc   = 1'b1;
				res_fire  = 1'b1;
				nxt_state = S_IDLE;
			end
			S_ARITH: begin
				if (md_done) begin
					top_dn    = md_result;
					ctl.pop   = 1'b1;
					cnt_dec   = 1'b1;
					res_fire  = 1'b1;
					nxt_state = S_IDLE;
				end
			end
			default: begin
				nxt_state = S_IDLE;
			end
		endcase
	end

	assign cnt_d = cnt_inc ? cnt_q + CW'(1) : (cnt_dec ? cnt_q - CW'(1) : cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			halted_q <= 1'b0;
			def_q    <= '0;
		end else begin
			cnt_q <= cnt_d;
			if (res_fire && res_status != STAT_OK) begin
				halted_q <= 1'b1;
			end
			if (ram_we) begin
				def_q[vi] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Result assembly and output buffering
	// ------------------------------------------------------------------
	assign pv_wide    = {{CONST_W{res_pval[DATA_WIDTH-1]}}, res_pval};
	assign depth_wide = {{DEPTH_OUT_W{1'b0}}, cnt_d};

	always_comb begin
		res_d.print_valid = res_print;
		res_d.print_value = pv_wide[CONST_W-1:0];
		res_d.status      = res_status;
		res_d.stack_depth = depth_wide[DEPTH_OUT_W-1:0];
	end

	assign out_taken   = out_valid_q && out_ready;
	assign out_ld_skid = out_taken && skid_valid_q;
	assign out_ld_res  = res_fire && (!out_valid_q || (out_taken && !skid_valid_q));
	assign skid_ld     = res_fire && out_valid_q && !out_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_ld_skid || out_ld_res) begin
				out_valid_q <= 1'b1;
			end else if (out_taken) begin
				out_valid_q <= 1'b0;
			end
			if (skid_ld) begin
				skid_valid_q <= 1'b1;
			end else if (out_ld_skid) begin
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld_skid) begin
			out_q <= skid_q;
		end else if (out_ld_res) begin
			out_q <= res_d;
		end
		if (skid_ld) begin
			skid_q <= res_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign print_valid = out_q.print_valid;
	assign print_value = out_q.print_value;
	assign status      = out_q.status;
	assign stack_depth = out_q.stack_depth;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`SME_ASSERT_NXT(a_halt_sticky, halted_q, halted_q, "halt flag cleared without reset")
	`SME_ASSERT_IMP(a_depth_bound, 1'b1, cnt_q <= CW'(STACK_DEPTH), "stack count past depth")
	`SME_ASSERT_IMP(a_skid_order, skid_valid_q, out_valid_q, "skid entry without output entry")
	`SME_ASSERT_IMP(a_fire_room, res_fire, !skid_valid_q, "result finished with skid full")
	`SME_ASSERT_IMP(a_md_state, md_done, state_q == S_ARITH, "muldiv done outside arith wait")
	`SME_ASSERT_NXT(a_halt_reply, accept && halted_q, out_valid_q, "halted request gave no result")

endmodule

`default_nettype wire

// ===== sim/stack_machine_executor_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor checker
// Watches both channels, predicts each result from the accepted requests and
// compares every delivered result against the oldest prediction.
// ----------------------------------------------------------------------------

module stack_machine_executor_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_ready,
	input  logic [sme_pkg::CMD_W-1:0]          cmd,
	input  logic [sme_pkg::CONST_W-1:0]        const_value,
	input  logic [sme_pkg::VAR_INDEX_W-1:0]    var_index,
	input  logic                               out_valid,
	input  logic                               out_ready,
	input  logic                               print_valid,
	input  logic [sme_pkg::CONST_W-1:0]        print_value,
	input  logic [sme_pkg::STATUS_W-1:0]       status,
	input  logic [sme_pkg::DEPTH_OUT_W-1:0]    stack_depth,
	output int                                 mismatch_count,
	output int                                 pending_results,
	output int                                 checked_results
);

	import sme_pkg::*;

	localparam int STACK_SLOTS = 16;
	localparam int VAR_SLOTS   = 16;

	// shadow machine state
	logic [CONST_W-1:0] stack_mem [STACK_SLOTS];
	logic [CONST_W-1:0] var_mem   [VAR_SLOTS];
	logic               var_defined [VAR_SLOTS];
	int                 depth;
	logic               halted;

	result_t            predicted_results [$];
	int                 fail_total;
	int                 checked_total;

	// run one instruction on the shadow machine, return its result
	function automatic result_t execute_instr(input cmd_t op, input logic [CONST_W-1:0] cv,
			input logic [VAR_INDEX_W-1:0] vi);
		result_t            r;
		logic [CONST_W-1:0] a, b, ma, mb, q;
		int                 slot;
		slot          = int'(vi) % VAR_SLOTS;
		r.print_valid = 1'b0;
		r.print_value = '0;
		r.status      = STAT_OK;
		if (halted) begin
			r.status = STAT_HALT;
		end else begin
			case (op)
				CMD_PUSH: begin
					if (depth >= STACK_SLOTS) r.status = STAT_OVER;
					else begin
						stack_mem[depth] = cv;
						depth++;
					end
				end
				CMD_LOAD: begin
					// undefined variable wins over a full stack
					if (!var_defined[slot]) r.status = STAT_UNDEF;
					else if (depth >= STACK_SLOTS) r.status = STAT_OVER;
					else begin
						stack_mem[depth] = var_mem[slot];
						depth++;
					end
				end
				CMD_STORE: begin
					if (depth == 0) r.status = STAT_UNDER;
					else begin
						depth--;
						var_mem[slot]     = stack_mem[depth];
						var_defined[slot] = 1'b1;
					end
				end
				CMD_PRINT: begin
					if (depth == 0) r.status = STAT_UNDER;
					else begin
						depth--;
						r.print_valid = 1'b1;
						r.print_value = stack_mem[depth];
					end
				end
				default: begin
					if (depth < 2) begin
						r.status = STAT_UNDER;
					end else begin
						b = stack_mem[depth-1];
						a = stack_mem[depth-2];
						if (op == CMD_DIV && b == '0) begin
							r.status = STAT_DIVZ;
						end else begin
							case (op)
								CMD_ADD: q = a + b;
								CMD_SUB: q = a - b;
								CMD_MUL: q = a * b;
								default: begin
									// truncating divide on magnitudes; MIN / -1 wraps to MIN
									ma = a[CONST_W-1] ? -a : a;
									mb = b[CONST_W-1] ? -b : b;
									q  = ma / mb;
									if (a[CONST_W-1] ^ b[CONST_W-1]) q = -q;
								end
							endcase
							depth--;
							stack_mem[depth-1] = q;
						end
					end
				end
			endcase
			if (r.status != STAT_OK) halted = 1'b1;
		end
		r.stack_depth = depth[DEPTH_OUT_W-1:0];
		return r;
	endfunction

	function automatic void note_failure(input string msg);
		fail_total++;
		if (fail_total <= 10) $display("%s", msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			depth  = 0;
			halted = 1'b0;
			for (int i = 0; i < VAR_SLOTS; i++) var_defined[i] = 1'b0;
			predicted_results.delete();
			fail_total      = 0;
			checked_total   = 0;
			mismatch_count  <= 0;
			pending_results <= 0;
			checked_results <= 0;
		end else begin
			// a result leaving now belongs to an earlier request, so pop first
			if (out_valid && out_ready) begin
				if (predicted_results.size() == 0) begin
					note_failure($sformatf("unexpected result: valid=%0b value=%0d status=%0d depth=%0d",
						print_valid, $signed(print_value), status, stack_depth));
				end else begin
					want = predicted_results.pop_front();
					checked_total++;
					if (print_valid !== want.print_valid || print_value !== want.print_value ||
							status !== want.status || stack_depth !== want.stack_depth)
						note_failure($sformatf({"result %0d mismatch: expected valid=%0b value=%0d",
							" status=%0d depth=%0d, got valid=%0b value=%0d status=%0d depth=%0d"},
							checked_total, want.print_valid, $signed(want.print_value), want.status,
							want.stack_depth, print_valid, $signed(print_value), status,
							stack_depth));
				end
			end
			if (in_valid && in_ready)
				predicted_results.push_back(execute_instr(cmd_t'(cmd), const_value, var_index));
			mismatch_count  <= fail_total;
			pending_results <= predicted_results.size();
			checked_results <= checked_total;
		end
	end

endmodule

// ===== sim/stack_machine_executor_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine executor testbench
// Directed and random instruction streams with random idling on both sides;
// a single induced error at the end exercises the sticky halt.
// ----------------------------------------------------------------------------

module stack_machine_executor_test;

	import sme_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 640;
	localparam int HALTED_ITEMS = 30;
	// slot kept unwritten so a load of it can always raise undefined variable
	localparam logic [VAR_INDEX_W-1:0] SPARE_SLOT = 4'd15;

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic [CMD_W-1:0]          cmd         = '0;
	logic [CONST_W-1:0]        const_value = '0;
	logic [VAR_INDEX_W-1:0]    var_index   = '0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic                      print_valid;
	logic [CONST_W-1:0]        print_value;
	logic [STATUS_W-1:0]       status;
	logic [DEPTH_OUT_W-1:0]    stack_depth;

	int                        mismatch_count;
	int                        pending_results;
	int                        checked_results;

	// light shadow of the stack, only to keep the stream legal until the halt
	int                        sh_depth    = 0;
	logic                      sh_defined [16];
	logic                      top_nonzero = 1'b0;
	logic                      grow_mode   = 1'b0;
	logic                      quiet_mode  = 1'b0;
	int                        sent_count  = 0;
	int                        cycle_count = 0;
	int                        ready_hold  = 0;
	int                        halt_kind;
	string                     halt_names [6];

	stack_machine_executor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.const_value(const_value),
		.var_index  (var_index),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.print_valid(print_valid),
		.print_value(print_value),
		.status     (status),
		.stack_depth(stack_depth)
	);

	stack_machine_executor_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.const_value    (const_value),
		.var_index      (var_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.print_valid    (print_valid),
		.print_value    (print_value),
		.status         (status),
		.stack_depth    (stack_depth),
		.mismatch_count (mismatch_count),
		.pending_results(pending_results),
		.checked_results(checked_results)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stack_machine_executor_test: FAIL");
			$finish;
		end
	end

	// receiver: holds out_ready for a random stretch, stalls mostly short, a few long
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			ready_hold <= 0;
		end else if (quiet_mode) begin
			out_ready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else if ($urandom_range(0, 9) < 7) begin
			out_ready  <= 1'b1;
			ready_hold <= $urandom_range(0, 15);
		end else begin
			out_ready  <= 1'b0;
			ready_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3)
				: $urandom_range(10, 40);
		end
	end

	// sender gap before each request: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_mode || r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// constants biased toward the corners and small magnitudes
	function automatic logic [CONST_W-1:0] pick_const();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return 32'h0000_0001;
			5, 6: return 32'($urandom_range(0, 64)) - 32'd32;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [CONST_W-1:0] pick_nonzero();
		logic [CONST_W-1:0] v;
		v = pick_const();
		while (v == '0) v = pick_const();
		return v;
	endfunction

	// present one request and hold it until accepted; valid stays high on a zero gap
	task automatic send_instr(input cmd_t op, input logic [CONST_W-1:0] value,
			input logic [VAR_INDEX_W-1:0] slot);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		cmd         <= op;
		const_value <= value;
		var_index   <= slot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
		case (op)
			CMD_PUSH: begin
				sh_depth++;
				top_nonzero = (value != '0);
			end
			CMD_LOAD: begin
				sh_depth++;
				top_nonzero = 1'b0;
			end
			CMD_STORE: begin
				sh_depth--;
				sh_defined[slot] = 1'b1;
				top_nonzero      = 1'b0;
			end
			default: begin
				sh_depth--;
				top_nonzero = 1'b0;
			end
		endcase
	endtask

	// one random request that cannot fail on the current stack
	task automatic send_random_legal();
		cmd_t                   op;
		logic [CONST_W-1:0]     value;
		logic [VAR_INDEX_W-1:0] slot;
		logic                   ok;
		ok = 1'b0;
		while (!ok) begin
			if (grow_mode && $urandom_range(0, 9) < 6) op = CMD_PUSH;
			else op = cmd_t'($urandom_range(0, 7));
			value = $urandom();
			slot  = $urandom_range(0, 15);
			case (op)
				CMD_PUSH: begin
					ok    = (sh_depth < 16);
					value = pick_const();
				end
				CMD_LOAD: begin
					ok = (sh_depth < 16);
					if (ok) begin
						slot = $urandom_range(0, 14);
						while (!sh_defined[slot]) slot = $urandom_range(0, 14);
					end
				end
				CMD_STORE: begin
					ok   = (sh_depth > 0);
					slot = $urandom_range(0, 14);
				end
				CMD_PRINT: ok = (sh_depth > 0);
				CMD_DIV: begin
					if (sh_depth >= 2 && top_nonzero) begin
						ok = 1'b1;
					end else if (sh_depth >= 1 && sh_depth < 16) begin
						// set up a safe divisor for a later divide
						op    = CMD_PUSH;
						value = pick_nonzero();
						ok    = 1'b1;
					end
				end
				default: ok = (sh_depth >= 2);
			endcase
		end
		send_instr(op, value, slot);
	endtask

	task automatic drain_to(input int n);
		while (sh_depth > n) send_instr(CMD_PRINT, $urandom(), $urandom_range(0, 15));
	endtask

	task automatic fill_stack();
		while (sh_depth < 16) send_instr(CMD_PUSH, pick_const(), $urandom_range(0, 15));
	endtask

	// drop valid and wait until every predicted result has been delivered
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	initial begin
		halt_names = '{"store/print underflow", "binary-op underflow", "divide by zero",
			"undefined load on full stack", "push overflow", "load overflow"};
		for (int i = 0; i < 16; i++) sh_defined[i] = 1'b0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: wrap corners of add/sub/mul, MIN / -1, truncation toward zero,
		// store/load round trip on low and high slots, print of a negative value
		send_instr(CMD_PUSH,  32'h7fff_ffff, 4'd0);
		send_instr(CMD_PUSH,  32'h0000_0001, 4'd0);
		send_instr(CMD_ADD,   32'h0000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'h0000_0001, 4'd0);
		send_instr(CMD_SUB,   32'h0000_0000, 4'd0);
		send_instr(CMD_STORE, 32'h0000_0000, 4'd0);
		send_instr(CMD_LOAD,  32'h0000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'hffff_ffff, 4'd0);
		send_instr(CMD_MUL,   32'h0000_0000, 4'd0);
		send_instr(CMD_PRINT, 32'h0000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'h8000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'hffff_ffff, 4'd0);
		send_instr(CMD_DIV,   32'h0000_0000, 4'd0);
		send_instr(CMD_PUSH,  -32'd7,        4'd0);
		send_instr(CMD_PUSH,  32'd2,         4'd0);
		send_instr(CMD_DIV,   32'h0000_0000, 4'd0);
		send_instr(CMD_DIV,   32'h0000_0000, 4'd0);
		send_instr(CMD_STORE, 32'hffff_ffff, 4'd9);
		send_instr(CMD_PUSH,  32'h0000_0000, 4'd0);
		send_instr(CMD_LOAD,  32'hffff_ffff, 4'd9);
		send_instr(CMD_MUL,   32'h0000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'h8000_0000, 4'd0);
		send_instr(CMD_PUSH,  32'h8000_0000, 4'd0);
		send_instr(CMD_MUL,   32'h0000_0000, 4'd0);
		send_instr(CMD_PRINT, 32'h0000_0000, 4'd15);

		wait_idle();

		// random legal stream; grow mode drives the stack up to full now and then
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) grow_mode = $urandom_range(0, 1);
			if (n == 150) quiet_mode <= 1'b1;   // back-to-back stretch, no stalls
			if (n == 230) quiet_mode <= 1'b0;
			if (n == 320) wait_idle();          // sender holds off until drained
			send_random_legal();
		end

		// one error to trip the sticky halt
		halt_kind = $urandom_range(0, 5);
		case (halt_kind)
			0: begin
				drain_to(0);
				send_instr($urandom_range(0, 1) ? CMD_STORE : CMD_PRINT, $urandom(),
					$urandom_range(0, 14));
			end
			1: begin
				// a lone zero on the stack: underflow is reported ahead of divide by zero
				drain_to(0);
				send_instr(CMD_PUSH, 32'h0000_0000, 4'd0);
				send_instr(cmd_t'($urandom_range(CMD_ADD, CMD_DIV)), $urandom(), 4'd0);
			end
			2: begin
				drain_to(10);
				send_instr(CMD_PUSH, pick_const(), 4'd0);
				send_instr(CMD_PUSH, 32'h0000_0000, 4'd0);
				send_instr(CMD_DIV, $urandom(), $urandom_range(0, 15));
			end
			3: begin
				fill_stack();
				send_instr(CMD_LOAD, $urandom(), SPARE_SLOT);
			end
			4: begin
				fill_stack();
				send_instr(CMD_PUSH, pick_const(), $urandom_range(0, 15));
			end
			default: begin
				fill_stack();
				send_instr(CMD_LOAD, $urandom(), 4'd0);
			end
		endcase

		// everything after the halt must report halted
		for (int n = 0; n < HALTED_ITEMS; n++)
			send_instr(cmd_t'($urandom_range(0, 7)), $urandom(), $urandom_range(0, 15));

		wait_idle();
		repeat (40) @(posedge clk);

		$display("Covered %0d requests, %0d results checked, %0d mismatches.",
			sent_count, checked_results, mismatch_count);
		$display("Halt was induced by %s, followed by %0d halted requests.",
			halt_names[halt_kind], HALTED_ITEMS);
		if (mismatch_count == 0 && pending_results == 0) begin
			$display("stack_machine_executor_test: PASS");
		end else begin
			if (pending_results != 0)
				$display("%0d results never arrived", pending_results);
			$display("stack_machine_executor_test: FAIL");
		end
		$finish;
	end

endmodule
